// ----- rtl/vna_pkg.sv -----
`default_nettype none
package vna_pkg;
   // field widths
   localparam int unsigned OP_W   = 2;
   localparam int unsigned IDX_W  = 12;
   localparam int unsigned POS_W  = 24;
   localparam int unsigned ACC_W  = 64;
   localparam int unsigned NRM_W  = 16;
   localparam int unsigned REQ_W  = 112;
   localparam int unsigned RSP_W  = 48;
   localparam int unsigned MUL_W  = 32;
   localparam int unsigned ROOT_W = 32;
   localparam int unsigned NUM_W  = 46;

   localparam int unsigned MAX_VERTICES_DEF = 4096;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OP_W-1:0] OP_TRI  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   // Q1.14 constants
   localparam logic [NRM_W-1:0] Q14_ONE  = 16'd16384;
   localparam logic [NRM_W-1:0] Q14_HALF = 16'd8192;
endpackage
`default_nettype wire

// ----- rtl/vertex_normal_accumulator.sv -----
`default_nettype none
// channel | direction | ports                            | contents
// req     | in        | req_tvalid req_tready req_tdata  | load, triangle or read item
// rsp     | out       | rsp_tvalid rsp_tready rsp_tdata  | unit normal of a read
//         |           | rsp_tuser                        | zero length flag
// triangle: three position reads, six products through the shared multiplier and
// three accumulator updates; a triangle with an invalid or repeated index is skipped.
// read: a zero accumulator skips the arithmetic; otherwise the magnitudes shift until
// the largest fits, then the bit-serial square root and three divides set the result.
// one item at a time; a waiting result holds the block after its next read.
// reset is synchronous; memories hold no reset and need no clearing pass.
module vertex_normal_accumulator #(
   parameter int unsigned MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // operation, index_first, index_second, index_third, pos_x_in, pos_y_in, pos_z_in
   input  wire logic [vna_pkg::REQ_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // normal_x, normal_y, normal_z
   output logic [vna_pkg::RSP_W-1:0]        rsp_tdata,
   // zero_length
   output logic                             rsp_tuser
);
   localparam int unsigned AW    = $clog2(MAX_VERTICES);
   localparam int unsigned POS3  = 3 * vna_pkg::POS_W;
   localparam int unsigned ACC3  = 3 * vna_pkg::ACC_W;
   localparam int unsigned DIF_W = vna_pkg::POS_W + 1;
   localparam int unsigned PRD_W = 2 * vna_pkg::MUL_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_T_RD, ST_T_MUL, ST_T_ARD, ST_T_AWR,
      ST_R_ARD, ST_R_AGET, ST_R_SHIFT, ST_R_SQ, ST_R_ROOT, ST_R_RWAIT,
      ST_R_DIV, ST_R_DWAIT, ST_R_OUT
   } state_type;

   state_type state_ff;

   // item fields
   logic [vna_pkg::OP_W-1:0]  req_op;
   logic [vna_pkg::IDX_W-1:0] req_i1, req_i2, req_i3;
   logic [POS3-1:0]           req_pos;

   assign req_op  = req_tdata[1:0];
   assign req_i1  = req_tdata[13:2];
   assign req_i2  = req_tdata[25:14];
   assign req_i3  = req_tdata[37:26];
   assign req_pos = req_tdata[109:38];

   logic [AW-1:0]     vidx_ff [3];
   logic [POS3-1:0]   pos_ff;
   logic              idx_ok_ff;
   logic [2:0]        cnt_ff;
   logic [1:0]        vi_ff;
   logic signed [vna_pkg::POS_W-1:0] pa_ff [3];
   logic signed [DIF_W-1:0] t_ff [3];
   logic signed [DIF_W-1:0] b_ff [3];
   logic [vna_pkg::ACC_W-1:0] n_ff [3];
   logic [vna_pkg::ACC_W-1:0] m_ff [3];
   logic [2:0]                neg_ff;
   logic [vna_pkg::ACC_W-1:0] sum_ff;
   logic [vna_pkg::ROOT_W-1:0] len_ff;
   logic [vna_pkg::NRM_W-1:0] nrm_ff [3];
   logic                      zero_ff;
   logic                      rsp_valid_ff;
   logic [vna_pkg::RSP_W-1:0] rsp_data_ff;
   logic                      rsp_user_ff;
   logic [1:0]                prod_sel;

   // cross product component fed by the product now leaving the multiplier
   assign prod_sel = 2'((cnt_ff - 3'd1) >> 1);

   // memories
   logic            pos_we, acc_we;
   logic [AW-1:0]   pos_rd_addr, acc_rd_addr, acc_wr_addr;
   logic [POS3-1:0] pos_rd_data;
   logic [ACC3-1:0] acc_rd_data, acc_wr_data;

   vna_ram #(.WIDTH(POS3), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (vidx_ff[0]),
      .wr_data (pos_ff),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd_data)
   );

   vna_ram #(.WIDTH(ACC3), .DEPTH(MAX_VERTICES)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   // shared multiplier
   logic signed [vna_pkg::MUL_W-1:0] mul_a, mul_b;
   logic signed [PRD_W-1:0]          mul_p;

   vna_mul u_mul (
      .clock      (clock),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .product_ff (mul_p)
   );

   // root and divide units
   logic                        root_go, root_done, div_go, div_done;
   logic [vna_pkg::ROOT_W-1:0]  root_val;
   logic [vna_pkg::NRM_W-1:0]   quot;
   logic [vna_pkg::NUM_W-1:0]   div_num;

   vna_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_go),
      .radicand (sum_ff),
      .done_ff  (root_done),
      .root     (root_val)
   );

   vna_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_num),
      .divisor  (len_ff),
      .done_ff  (div_done),
      .quot_ff  (quot)
   );

   function automatic logic [vna_pkg::ACC_W-1:0] sat_add(
      input logic [vna_pkg::ACC_W-1:0] a,
      input logic [vna_pkg::ACC_W-1:0] b
   );
      logic [vna_pkg::ACC_W-1:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return s;
   endfunction

   function automatic logic [vna_pkg::ACC_W-1:0] mag(input logic [vna_pkg::ACC_W-1:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic idx_valid(input logic [vna_pkg::IDX_W-1:0] i);
      return 32'(i) < MAX_VERTICES;
   endfunction

   // memory port and unit control
   always_comb begin
      pos_we      = (state_ff == ST_LOAD) && idx_ok_ff;
      pos_rd_addr = vidx_ff[(cnt_ff[1:0] == 2'd3) ? 2'd2 : cnt_ff[1:0]];
      acc_rd_addr = (state_ff == ST_T_ARD) ? vidx_ff[vi_ff] : vidx_ff[0];
      acc_we      = ((state_ff == ST_LOAD) && idx_ok_ff) || (state_ff == ST_T_AWR);
      acc_wr_addr = (state_ff == ST_T_AWR) ? vidx_ff[vi_ff] : vidx_ff[0];
      if (state_ff == ST_T_AWR) begin
         acc_wr_data = {sat_add(acc_rd_data[191:128], n_ff[2]),
                        sat_add(acc_rd_data[127:64], n_ff[1]),
                        sat_add(acc_rd_data[63:0], n_ff[0])};
      end else begin
         acc_wr_data = '0;
      end
      root_go = (state_ff == ST_R_ROOT);
      div_go  = (state_ff == ST_R_DIV);
      div_num = vna_pkg::NUM_W'({m_ff[vi_ff][30:0], 14'd0})
              + vna_pkg::NUM_W'(len_ff[vna_pkg::ROOT_W-1:1]);
   end

   // multiplier operands: cross product terms, then squares
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_T_MUL) begin
         case (cnt_ff)
            3'd0: begin mul_a = 32'(t_ff[1]); mul_b = 32'(b_ff[2]); end
            3'd1: begin mul_a = 32'(t_ff[2]); mul_b = 32'(b_ff[1]); end
            3'd2: begin mul_a = 32'(t_ff[2]); mul_b = 32'(b_ff[0]); end
            3'd3: begin mul_a = 32'(t_ff[0]); mul_b = 32'(b_ff[2]); end
            3'd4: begin mul_a = 32'(t_ff[0]); mul_b = 32'(b_ff[1]); end
            3'd5: begin mul_a = 32'(t_ff[1]); mul_b = 32'(b_ff[0]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (state_ff == ST_R_SQ && cnt_ff < 3'd3) begin
         mul_a = $signed(m_ff[cnt_ff[1:0]][vna_pkg::MUL_W-1:0]);
         mul_b = $signed(m_ff[cnt_ff[1:0]][vna_pkg::MUL_W-1:0]);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         vi_ff        <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_R_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               vi_ff  <= '0;
               if (req_tvalid) begin
                  vidx_ff[0] <= (req_op == vna_pkg::OP_TRI) ? AW'(req_i3) : AW'(req_i1);
                  vidx_ff[1] <= AW'(req_i2);
                  vidx_ff[2] <= AW'(req_i1);
                  pos_ff     <= req_pos;
                  idx_ok_ff  <= idx_valid(req_i1);
                  for (int i = 0; i < 3; i++) begin
                     n_ff[i] <= '0;
                  end
                  if (req_op == vna_pkg::OP_LOAD) begin
                     state_ff   <= ST_LOAD;
                  end else if (req_op == vna_pkg::OP_TRI) begin
                     if (idx_valid(req_i1) && idx_valid(req_i2) && idx_valid(req_i3)
                         && req_i1 != req_i2 && req_i2 != req_i3 && req_i1 != req_i3) begin
                        state_ff <= ST_T_RD;
                     end
                  end else if (req_op == vna_pkg::OP_READ) begin
                     state_ff   <= ST_R_ARD;
                  end
               end
            end
            ST_LOAD: begin
               state_ff <= ST_IDLE;
            end
            // read A, B, C positions; form edge differences
            ST_T_RD: begin
               for (int i = 0; i < 3; i++) begin
                  if (cnt_ff == 3'd1) begin
                     pa_ff[i] <= $signed(pos_rd_data[i*24 +: 24]);
                  end
                  if (cnt_ff == 3'd2) begin
                     t_ff[i] <= DIF_W'($signed(pos_rd_data[i*24 +: 24])) - DIF_W'(pa_ff[i]);
                  end
                  if (cnt_ff == 3'd3) begin
                     b_ff[i] <= DIF_W'(pa_ff[i]) - DIF_W'($signed(pos_rd_data[i*24 +: 24]));
                  end
               end
               if (cnt_ff == 3'd3) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_T_MUL;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            // six products folded into the cross product
            ST_T_MUL: begin
               if (cnt_ff != 3'd0) begin
                  if (cnt_ff[0]) begin
                     n_ff[prod_sel] <= n_ff[prod_sel] + mul_p;
                  end else begin
                     n_ff[prod_sel] <= n_ff[prod_sel] - mul_p;
                  end
               end
               if (cnt_ff == 3'd6) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_T_ARD;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            ST_T_ARD: begin
               state_ff <= ST_T_AWR;
            end
            ST_T_AWR: begin
               vi_ff <= vi_ff + 2'd1;
               state_ff <= (vi_ff == 2'd2) ? ST_IDLE : ST_T_ARD;
            end
            ST_R_ARD: begin
               state_ff <= ST_R_AGET;
            end
            // magnitudes and signs of the accumulator
            ST_R_AGET: begin
               for (int i = 0; i < 3; i++) begin
                  m_ff[i]   <= idx_ok_ff ? mag(acc_rd_data[i*64 +: 64]) : '0;
                  neg_ff[i] <= idx_ok_ff && acc_rd_data[i*64 + 63];
               end
               if (!idx_ok_ff || acc_rd_data == '0) begin
                  for (int i = 0; i < 3; i++) begin
                     nrm_ff[i] <= vna_pkg::Q14_HALF;
                  end
                  zero_ff  <= 1'b1;
                  state_ff <= ST_R_OUT;
               end else begin
                  zero_ff  <= 1'b0;
                  state_ff <= ST_R_SHIFT;
               end
            end
            // common right shift until all fit 31 bits
            ST_R_SHIFT: begin
               if ((m_ff[0][63:31] | m_ff[1][63:31] | m_ff[2][63:31]) != '0) begin
                  for (int i = 0; i < 3; i++) begin
                     m_ff[i] <= m_ff[i] >> 1;
                  end
               end else begin
                  cnt_ff   <= '0;
                  sum_ff   <= '0;
                  state_ff <= ST_R_SQ;
               end
            end
            ST_R_SQ: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff != 3'd0) begin
                  sum_ff <= sum_ff + mul_p;
               end
               if (cnt_ff == 3'd3) begin
                  state_ff <= ST_R_ROOT;
               end
            end
            ST_R_ROOT: begin
               state_ff <= ST_R_RWAIT;
            end
            ST_R_RWAIT: begin
               if (root_done) begin
                  len_ff   <= (root_val == '0) ? 32'd1 : root_val;
                  vi_ff    <= '0;
                  state_ff <= ST_R_DIV;
               end
            end
            ST_R_DIV: begin
               state_ff <= ST_R_DWAIT;
            end
            // clamp and sign each quotient
            ST_R_DWAIT: begin
               if (div_done) begin
                  if (neg_ff[vi_ff]) begin
                     nrm_ff[vi_ff] <= -((quot > vna_pkg::Q14_ONE) ? vna_pkg::Q14_ONE : quot);
                  end else begin
                     nrm_ff[vi_ff] <= (quot > vna_pkg::Q14_ONE) ? vna_pkg::Q14_ONE : quot;
                  end
                  vi_ff    <= vi_ff + 2'd1;
                  state_ff <= (vi_ff == 2'd2) ? ST_R_OUT : ST_R_DIV;
               end
            end
            ST_R_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {nrm_ff[2], nrm_ff[1], nrm_ff[0]};
                  rsp_user_ff  <= zero_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a zero length result carries one half in every component
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == {3{vna_pkg::Q14_HALF}})
      else $error("zero length result without half defaults");

   // each component of a unit normal stays within plus or minus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         ($signed(rsp_tdata[15:0]) <= 16384 && $signed(rsp_tdata[15:0]) >= -16384
          && $signed(rsp_tdata[31:16]) <= 16384 && $signed(rsp_tdata[31:16]) >= -16384
          && $signed(rsp_tdata[47:32]) <= 16384 && $signed(rsp_tdata[47:32]) >= -16384))
      else $error("normal component out of range");

   // accumulators and positions are never written while waiting for an item
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !acc_we && !pos_we)
      else $error("memory write while idle");
endmodule
`default_nettype wire

// ----- rtl/vna_ram.sv -----
`default_nettype none
module vna_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/vna_mul.sv -----
`default_nettype none
module vna_mul (
   input  wire logic                                  clock,
   input  wire logic signed [vna_pkg::MUL_W-1:0]      op_a,
   input  wire logic signed [vna_pkg::MUL_W-1:0]      op_b,
   output logic signed [2*vna_pkg::MUL_W-1:0]         product_ff
);
   // shared signed multiplier, registered result
   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end
endmodule
`default_nettype wire

// ----- rtl/vna_isqrt.sv -----
`default_nettype none
module vna_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [vna_pkg::ACC_W-1:0]     radicand,
   output logic                               done_ff,
   output logic [vna_pkg::ROOT_W-1:0]         root
);
   logic [vna_pkg::ACC_W-1:0] x_ff;
   logic [vna_pkg::ACC_W-1:0] res_ff;
   logic [vna_pkg::ACC_W-1:0] bit_ff;
   logic                      busy_ff;
   logic [vna_pkg::ACC_W-1:0] trial;

   assign trial = res_ff + bit_ff;
   assign root  = res_ff[vna_pkg::ROOT_W-1:0];

   // one result bit a cycle, two radicand bits a step
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         x_ff    <= radicand;
         res_ff  <= '0;
         bit_ff  <= 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_ff   <= x_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff  <= bit_ff >> 2;
         done_ff <= bit_ff[0];
         if (bit_ff[0]) begin
            busy_ff <= 1'b0;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/vna_div.sv -----
`default_nettype none
module vna_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [vna_pkg::NUM_W-1:0]     dividend,
   input  wire logic [vna_pkg::ROOT_W-1:0]    divisor,
   output logic                               done_ff,
   output logic [vna_pkg::NRM_W-1:0]          quot_ff
);
   localparam int unsigned CNT_W = $clog2(vna_pkg::NRM_W);

   logic [vna_pkg::ROOT_W-1:0] rem_ff;
   logic [vna_pkg::NRM_W-1:0]  low_ff;
   logic [vna_pkg::ROOT_W-1:0] den_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       busy_ff;
   logic [vna_pkg::ROOT_W:0]   rem_in;

   assign rem_in = {rem_ff, low_ff[vna_pkg::NRM_W-1]};

   // restoring division, one quotient bit a cycle; upper part starts below divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         rem_ff  <= vna_pkg::ROOT_W'(dividend[vna_pkg::NUM_W-1:vna_pkg::NRM_W]);
         low_ff  <= dividend[vna_pkg::NRM_W-1:0];
         den_ff  <= divisor;
         cnt_ff  <= '0;
         quot_ff <= '0;
      end else if (busy_ff) begin
         low_ff <= low_ff << 1;
         if (rem_in >= {1'b0, den_ff}) begin
            rem_ff  <= vna_pkg::ROOT_W'(rem_in - {1'b0, den_ff});
            quot_ff <= {quot_ff[vna_pkg::NRM_W-2:0], 1'b1};
         end else begin
            rem_ff  <= vna_pkg::ROOT_W'(rem_in);
            quot_ff <= {quot_ff[vna_pkg::NRM_W-2:0], 1'b0};
         end
         cnt_ff  <= cnt_ff + 1'b1;
         done_ff <= (cnt_ff == CNT_W'(vna_pkg::NRM_W - 1));
         if (cnt_ff == CNT_W'(vna_pkg::NRM_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire
